### design/mono_bitmap_span_rop_top_assert.svh
// Assertion macros shared by the span raster-op block.
`ifndef MONO_BITMAP_SPAN_ROP_TOP_ASSERT_SVH
`define MONO_BITMAP_SPAN_ROP_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MBSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mbsr assertion failed");

// Next-cycle implication, checked outside reset.
`define MBSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mbsr assertion failed");

`endif

### design/mbsr_pkg.sv
// Shared constants and controller/datapath interface types for the span raster-op block.
package mbsr_pkg;

    // Frame store geometry; the byte count is a power of two so addresses wrap by truncation.
    localparam int MEM_BYTES = 32768;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int MAX_X     = 1023;

    // Fixed field widths of the item.
    localparam int BA_W      = 15;
    localparam int X_W       = 10;
    localparam int XB_W      = X_W - 3;
    localparam int TOUCH_W   = 8;
    localparam int PAT_W     = 64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;        // capture the accepted item
        logic clr_wr;       // write one zero byte of the clearing pass
        logic rd_first;     // read the first addressed byte
        logic span_step;    // write the current span byte, read the next
        logic finish_load;  // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;     // clearing pass is at its last byte
        logic is_read;      // held item is a pixel read
        logic span_ok;      // held item is a span with a valid range
        logic span_last;    // current span byte is the last one
        logic out_busy;     // result register full and not taken this cycle
    } t_dp_sts;

endpackage

### design/mbsr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module mbsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read; read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/mbsr_ctrl.sv
// Controller state machine: clearing pass, item intake, span sequencing, result hand-off.
module mbsr_ctrl
    import mbsr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    `include "mono_bitmap_span_rop_top_assert.svh"

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_FETCH = 5'b00100,
        S_SPAN  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.rd_first = i_sts.is_read | i_sts.span_ok;
                n_state        = i_sts.span_ok ? S_SPAN : S_DONE;
            end
            S_SPAN: begin
                o_cmd.span_step = 1'b1;
                if (i_sts.span_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish_load = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `MBSR_ASSERT_NEXT(a_accept_fetch, i_clk, i_rst_n, o_in_ready && i_in_valid, r_state == S_FETCH)
    `MBSR_ASSERT_NOW(a_no_load_busy, i_clk, i_rst_n, o_cmd.finish_load, !i_sts.out_busy)
    `MBSR_ASSERT_NOW(a_clear_blocks, i_clk, i_rst_n, o_cmd.clr_wr, !o_in_ready)

endmodule

### design/mbsr_dp.sv
// Datapath: item registers, pattern register, byte masks, raster ops, frame store, result.
module mbsr_dp
    import mbsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_cfg_wr_en,
    input  logic [PAT_W-1:0]   i_cfg_wr_data,
    input  logic [1:0]         i_opcode,
    input  logic [BA_W-1:0]    i_byte_address,
    input  logic [X_W-1:0]     i_x_start,
    input  logic [X_W-1:0]     i_x_end,
    input  logic               i_color,
    input  logic               i_background,
    input  logic [2:0]         i_mode,
    input  logic [2:0]         i_pattern_row,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_pixel_value,
    output logic [7:0]         o_byte_value,
    output logic [TOUCH_W-1:0] o_bytes_touched,
    output logic               o_range_error
);

    localparam logic [1:0] OP_ROP  = 2'd0;
    localparam logic [1:0] OP_PAT  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [2:0] MODE_REPLACE = 3'd0;
    localparam logic [2:0] MODE_XOR     = 3'd1;
    localparam logic [2:0] MODE_OR      = 3'd2;
    localparam logic [2:0] MODE_AND     = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    function automatic logic [X_W-1:0] clamp_x(input logic [X_W-1:0] x);
        return (x > X_W'(MAX_X)) ? X_W'(MAX_X) : x;
    endfunction

    logic [PAT_W-1:0]   r_pattern;
    logic [ADDR_W-1:0]  r_clr;
    logic [1:0]         r_opcode;
    logic [ADDR_W-1:0]  r_addr;
    logic [2:0]         r_xs_lo;
    logic [2:0]         r_xe_lo;
    logic [XB_W-1:0]    r_span;
    logic [XB_W-1:0]    r_idx;
    logic               r_color;
    logic [2:0]         r_mode;
    logic [7:0]         r_psrc;
    logic               r_err;
    logic               r_out_valid;
    logic               r_pix;
    logic [7:0]         r_bval;
    logic [TOUCH_W-1:0] r_touched;
    logic               r_rerr;

    logic [X_W-1:0]     xs_c;
    logic [X_W-1:0]     xe_c;
    logic [7:0]         pat_byte;
    logic [7:0]         psrc_in;
    logic [7:0]         rdata;
    logic [7:0]         mask;
    logic [7:0]         src;
    logic [7:0]         new_byte;
    logic               span_last;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;

    // Clamp columns and form the pattern source of the incoming item
    always_comb begin
        xs_c     = clamp_x(i_x_start);
        xe_c     = clamp_x(i_x_end);
        pat_byte = r_pattern[{i_pattern_row, 3'b000} +: 8];
        psrc_in  = i_color ? pat_byte : ~pat_byte;
        if (i_color == i_background) begin
            psrc_in = {8{i_color}};
        end
    end

    // Pattern register, written at any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
        end else if (i_cfg_wr_en) begin
            r_pattern <= i_cfg_wr_data;
        end
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Hold the item; advance the byte address and index through the span
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_opcode <= i_opcode;
            r_addr   <= i_byte_address[ADDR_W-1:0];
            r_xs_lo  <= xs_c[2:0];
            r_xe_lo  <= xe_c[2:0];
            r_span   <= xe_c[X_W-1:3] - xs_c[X_W-1:3];
            r_idx    <= '0;
            r_color  <= i_color;
            r_mode   <= i_mode;
            r_psrc   <= psrc_in;
            r_err    <= (xe_c < xs_c);
        end else if (i_cmd.span_step) begin
            r_addr <= r_addr + 1'b1;
            r_idx  <= r_idx + 1'b1;
        end
    end

    assign span_last = (r_idx == r_span);

    // Edge masks and the new byte value
    always_comb begin
        mask = 8'hff;
        if (r_idx == '0) begin
            mask = mask & (8'hff >> r_xs_lo);
        end
        if (span_last) begin
            mask = mask & (8'hff << (3'd7 - r_xe_lo));
        end
        src = r_color ? mask : 8'h00;
        if (r_opcode == OP_ROP) begin
            case (r_mode)
                MODE_XOR:     new_byte = rdata ^ src;
                MODE_OR:      new_byte = rdata | src;
                MODE_AND:     new_byte = rdata & (src | ~mask);
                MODE_CLEAR:   new_byte = rdata & ~mask;
                MODE_REPLACE: new_byte = (rdata & ~mask) | src;
                // spare modes draw as replace
                default:      new_byte = (rdata & ~mask) | src;
            endcase
        end else begin
            new_byte = (rdata & ~mask) | (r_psrc & mask);
        end
    end

    // Frame store port steering: clear, span write, first and next reads
    always_comb begin
        ram_we    = i_cmd.clr_wr | i_cmd.span_step;
        ram_waddr = i_cmd.clr_wr ? r_clr : r_addr;
        ram_wdata = i_cmd.clr_wr ? 8'h00 : new_byte;
        ram_re    = i_cmd.rd_first | (i_cmd.span_step & ~span_last);
        ram_raddr = i_cmd.rd_first ? r_addr : r_addr + 1'b1;
    end

    mbsr_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    // Result register valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish_load) begin
            if (r_opcode == OP_READ) begin
                r_pix     <= rdata[3'd7 - r_xs_lo];
                r_bval    <= rdata;
                r_touched <= '0;
                r_rerr    <= 1'b0;
            end else if ((r_opcode == OP_ROP) || (r_opcode == OP_PAT)) begin
                r_pix     <= 1'b0;
                r_bval    <= 8'h00;
                r_touched <= r_err ? '0 : TOUCH_W'(r_span) + 1'b1;
                r_rerr    <= r_err;
            end else begin
                r_pix     <= 1'b0;
                r_bval    <= 8'h00;
                r_touched <= '0;
                r_rerr    <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.clr_last  = (r_clr == ADDR_W'(MEM_BYTES - 1));
        o_sts.is_read   = (r_opcode == OP_READ);
        o_sts.span_ok   = ((r_opcode == OP_ROP) || (r_opcode == OP_PAT)) && !r_err;
        o_sts.span_last = span_last;
        o_sts.out_busy  = r_out_valid & ~i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_value   = r_pix;
    assign o_byte_value    = r_bval;
    assign o_bytes_touched = r_touched;
    assign o_range_error   = r_rerr;

endmodule

### design/mono_bitmap_span_rop_top.sv
// Top level of the one-bit frame store with span raster ops, pattern spans and pixel reads.
//
// Input channel i_in_valid/o_in_ready carries one command item: a raster-op span,
// a pattern span or a pixel read. Output channel o_out_valid/i_out_ready returns
// exactly one result item per command. i_cfg_wr_en/i_cfg_wr_data load the 64-bit
// fill pattern; write it only while no command is in flight.
// Sequencing: a span of N frame bytes (1 to 128) reads its first byte after acceptance,
// then the frame store does one read-modify-write per cycle (read of the next byte
// overlaps the write of the current one), and then the result register is loaded.
// A pixel read, a reversed span or an unused opcode skips the span writes.
// Another item is accepted in the cycle after the previous result is loaded, so a
// new item is not taken while one is still in flight.
// Reset: the frame store is cleared by a pass that writes one byte per cycle over
// all 32768 bytes; no item is accepted during it, configuration writes are.
// The fill pattern resets to zero. When the receiver stalls, the result waits in
// the output register; the next item is still accepted and runs, then holds its
// result until the register is free.
module mono_bitmap_span_rop_top
    import mbsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [PAT_W-1:0]   i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [BA_W-1:0]    i_byte_address,
    input  logic [X_W-1:0]     i_x_start,
    input  logic [X_W-1:0]     i_x_end,
    input  logic               i_color,
    input  logic               i_background,
    input  logic [2:0]         i_mode,
    input  logic [2:0]         i_pattern_row,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_pixel_value,
    output logic [7:0]         o_byte_value,
    output logic [TOUCH_W-1:0] o_bytes_touched,
    output logic               o_range_error
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mbsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mbsr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_opcode        (i_opcode),
        .i_byte_address  (i_byte_address),
        .i_x_start       (i_x_start),
        .i_x_end         (i_x_end),
        .i_color         (i_color),
        .i_background    (i_background),
        .i_mode          (i_mode),
        .i_pattern_row   (i_pattern_row),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_pixel_value   (o_pixel_value),
        .o_byte_value    (o_byte_value),
        .o_bytes_touched (o_bytes_touched),
        .o_range_error   (o_range_error)
    );

endmodule

### tb/mbsr_tb_pkg.sv
// Command and raster-op codes shared by the span raster-op testbench files.
package mbsr_tb_pkg;

    typedef enum logic [1:0] {
        OP_ROP_SPAN     = 2'd0,
        OP_PATTERN_SPAN = 2'd1,
        OP_READ_PIXEL   = 2'd2,
        OP_NONE         = 2'd3
    } t_mbsr_op;

    // Modes 5 to 7 are spare codes that draw as replace.
    typedef enum logic [2:0] {
        ROP_REPLACE = 3'd0,
        ROP_XOR     = 3'd1,
        ROP_OR      = 3'd2,
        ROP_AND     = 3'd3,
        ROP_CLEAR   = 3'd4,
        ROP_SPARE_5 = 3'd5,
        ROP_SPARE_6 = 3'd6,
        ROP_SPARE_7 = 3'd7
    } t_mbsr_rop;

endpackage

### tb/mbsr_result_check.sv
// Shadow frame store and result comparison for the span raster-op block.
module mbsr_result_check
    import mbsr_pkg::*;
    import mbsr_tb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [PAT_W-1:0]   i_cfg_wr_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [BA_W-1:0]    i_byte_address,
    input  logic [X_W-1:0]     i_x_start,
    input  logic [X_W-1:0]     i_x_end,
    input  logic               i_color,
    input  logic               i_background,
    input  logic [2:0]         i_mode,
    input  logic [2:0]         i_pattern_row,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_pixel_value,
    input  logic [7:0]         i_byte_value,
    input  logic [TOUCH_W-1:0] i_bytes_touched,
    input  logic               i_range_error,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic               pixel;
        logic [7:0]         byte_val;
        logic [TOUCH_W-1:0] touched;
        logic               range_err;
    } t_mbsr_result;

    logic [7:0]     shadow_frame [MEM_BYTES];
    logic [PAT_W-1:0] pattern_shadow;
    t_mbsr_result   command_outcomes [$];
    t_mbsr_result   want;
    int             mismatches;

    // Draw or read one command on the shadow store and return its result item.
    function automatic t_mbsr_result render_command(
        input t_mbsr_op         op,
        input logic [BA_W-1:0]  base,
        input logic [X_W-1:0]   xs,
        input logic [X_W-1:0]   xe,
        input logic             color,
        input logic             bg,
        input t_mbsr_rop        rop,
        input logic [2:0]       prow
    );
        t_mbsr_result      res;
        logic [7:0]        pat;
        logic [7:0]        src;
        logic [7:0]        mask;
        logic [7:0]        old;
        logic [7:0]        upd;
        logic [ADDR_W-1:0] addr;
        int                col;
        res = '0;
        case (op)
            OP_READ_PIXEL: begin
                old = shadow_frame[base];
                res.byte_val = old;
                res.pixel = old[3'd7 - xs[2:0]];
            end
            OP_ROP_SPAN, OP_PATTERN_SPAN: begin
                if (xe < xs) begin
                    res.range_err = 1'b1;
                end else begin
                    // invert the pattern byte for a zero foreground, go solid when fg == bg
                    pat = pattern_shadow[8*prow +: 8];
                    if (!color) pat = ~pat;
                    if (color == bg) pat = {8{color}};
                    for (col = xs[9:3]; col <= xe[9:3]; col++) begin
                        mask = 8'hff;
                        if (col == xs[9:3]) mask = mask & (8'hff >> xs[2:0]);
                        if (col == xe[9:3]) mask = mask & (8'hff << (3'd7 - xe[2:0]));
                        // wrap within the store
                        addr = ADDR_W'(base + col - xs[9:3]);
                        old = shadow_frame[addr];
                        src = color ? mask : 8'h00;
                        if (op == OP_PATTERN_SPAN) begin
                            upd = (old & ~mask) | (pat & mask);
                        end else begin
                            case (rop)
                                ROP_XOR:   upd = old ^ src;
                                ROP_OR:    upd = old | src;
                                ROP_AND:   upd = old & (src | ~mask);
                                ROP_CLEAR: upd = old & ~mask;
                                default:   upd = (old & ~mask) | src;
                            endcase
                        end
                        shadow_frame[addr] = upd;
                        res.touched = res.touched + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic flag_field(
        input string      field,
        input logic [7:0] exp_v,
        input logic [7:0] act_v
    );
        if (act_v !== exp_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (shadow_frame[a]) shadow_frame[a] = 8'h00;
            pattern_shadow = '0;
            command_outcomes.delete();
            mismatches = 0;
        end else begin
            // compare the returned item with the oldest outstanding command
            if (i_out_valid && i_out_ready) begin
                if (command_outcomes.size() == 0) begin
                    mismatches++;
                    $display("%0t: result item with nothing outstanding, expected none,%s",
                             $time, " actual");
                    $display("    %0h %0h %0d %0h",
                             i_pixel_value, i_byte_value, i_bytes_touched, i_range_error);
                end else begin
                    want = command_outcomes.pop_front();
                    flag_field("pixel_value", 8'(want.pixel), 8'(i_pixel_value));
                    flag_field("byte_value", want.byte_val, i_byte_value);
                    flag_field("bytes_touched", want.touched, i_bytes_touched);
                    flag_field("range_error", 8'(want.range_err), 8'(i_range_error));
                end
            end
            // track the fill pattern register
            if (i_cfg_wr_en) pattern_shadow = i_cfg_wr_data;
            // apply each accepted command to the shadow store
            if (i_in_valid && i_in_ready) begin
                command_outcomes.push_back(render_command(t_mbsr_op'(i_opcode), i_byte_address,
                    i_x_start, i_x_end, i_color, i_background, t_mbsr_rop'(i_mode),
                    i_pattern_row));
            end
        end
        o_pending    <= command_outcomes.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/tb_mono_bitmap_span_rop_top.sv
// Stimulus, handshake pressure and verdict for the span raster-op block.
module tb_mono_bitmap_span_rop_top;
    import mbsr_pkg::*;
    import mbsr_tb_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [PAT_W-1:0]   i_cfg_wr_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_opcode;
    logic [BA_W-1:0]    i_byte_address;
    logic [X_W-1:0]     i_x_start;
    logic [X_W-1:0]     i_x_end;
    logic               i_color;
    logic               i_background;
    logic [2:0]         i_mode;
    logic [2:0]         i_pattern_row;
    logic               o_out_valid;
    logic               i_out_ready = 1'b1;
    logic               o_pixel_value;
    logic [7:0]         o_byte_value;
    logic [TOUCH_W-1:0] o_bytes_touched;
    logic               o_range_error;

    int fail_count;
    int results_pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int op_count [4] = '{0, 0, 0, 0};
    int pattern_loads = 0;
    int phase;

    mono_bitmap_span_rop_top DUT (.*);

    mbsr_result_check u_result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_byte_address  (i_byte_address),
        .i_x_start       (i_x_start),
        .i_x_end         (i_x_end),
        .i_color         (i_color),
        .i_background    (i_background),
        .i_mode          (i_mode),
        .i_pattern_row   (i_pattern_row),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_pixel_value   (o_pixel_value),
        .i_byte_value    (o_byte_value),
        .i_bytes_touched (o_bytes_touched),
        .i_range_error   (o_range_error),
        .o_fail_count    (fail_count),
        .o_pending       (results_pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stall the result channel at the current rate.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hold one command item until accepted, then idle at the current rate.
    task automatic send_item(
        input t_mbsr_op         op,
        input logic [BA_W-1:0]  ba,
        input logic [X_W-1:0]   xs,
        input logic [X_W-1:0]   xe,
        input logic             color,
        input logic             bg,
        input t_mbsr_rop        rop,
        input logic [2:0]       prow
    );
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_byte_address <= ba;
        i_x_start      <= xs;
        i_x_end        <= xe;
        i_color        <= color;
        i_background   <= bg;
        i_mode         <= rop;
        i_pattern_row  <= prow;
        do @(posedge i_clk); while (!o_in_ready);
        op_count[op]++;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Hold off the sender until every outstanding result has returned or the wait gives up.
    task automatic wait_drained();
        int spin;
        i_in_valid <= 1'b0;
        spin = 0;
        do begin
            @(posedge i_clk);
            spin++;
        end while (results_pending != 0 && spin < 5000);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_pattern(input logic [PAT_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pattern_loads++;
    endtask

    // Mostly short spans and reads near both ends of the store, some long or reversed.
    task automatic send_random_item();
        t_mbsr_op        op;
        logic [BA_W-1:0] ba;
        logic [X_W-1:0]  xs;
        logic [X_W-1:0]  xe;
        int              pick;
        int              len;
        pick = $urandom_range(99);
        if (pick < 40) op = OP_ROP_SPAN;
        else if (pick < 70) op = OP_PATTERN_SPAN;
        else if (pick < 97) op = OP_READ_PIXEL;
        else op = OP_NONE;
        pick = $urandom_range(99);
        if (pick < 60) ba = BA_W'($urandom_range(255));
        else if (pick < 80) ba = BA_W'(15'h7f00 | $urandom_range(255));
        else ba = BA_W'($urandom);
        xs = X_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 6) begin
            xe = X_W'($urandom);
        end else if (pick < 10) begin
            xe = (xs == 0) ? 10'd0 : X_W'($urandom_range(xs - 1));
        end else if (pick < 14) begin
            xe = X_W'(MAX_X);
        end else begin
            len = $urandom_range(40);
            xe = (xs + len > MAX_X) ? X_W'(MAX_X) : X_W'(xs + len);
        end
        send_item(op, ba, xs, xe, 1'($urandom), 1'($urandom),
                  t_mbsr_rop'($urandom_range(7)), 3'($urandom));
    endtask

    initial begin
        #(24_000_000);
        $display("mono_bitmap_span_rop_top regression: fail");
        $finish;
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        i_in_valid     <= 1'b0;
        i_opcode       <= OP_NONE;
        i_byte_address <= '0;
        i_x_start      <= '0;
        i_x_end        <= '0;
        i_color        <= 1'b0;
        i_background   <= 1'b0;
        i_mode         <= ROP_REPLACE;
        i_pattern_row  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: cleared store and reset pattern first.
        send_item(OP_READ_PIXEL, 15'd0, 10'd0, 10'd0, 1'b0, 1'b0, ROP_REPLACE, 3'd0);
        send_item(OP_PATTERN_SPAN, 15'd0, 10'd0, 10'd15, 1'b1, 1'b0, ROP_REPLACE, 3'd3);
        wait_drained();
        load_pattern(64'h0123_4567_89ab_cdef);

        // Every raster op, spare modes, wrap, single byte and single pixel spans.
        send_item(OP_ROP_SPAN, 15'd0, 10'd0, 10'd1023, 1'b1, 1'b0, ROP_REPLACE, 3'd0);
        send_item(OP_READ_PIXEL, 15'd5, 10'd45, 10'd0, 1'b0, 1'b0, ROP_REPLACE, 3'd0);
        send_item(OP_ROP_SPAN, 15'h7fff, 10'd3, 10'd5, 1'b1, 1'b0, ROP_XOR, 3'd0);
        send_item(OP_ROP_SPAN, 15'h7ffe, 10'd0, 10'd31, 1'b1, 1'b1, ROP_OR, 3'd0);
        send_item(OP_ROP_SPAN, 15'd10, 10'd4, 10'd19, 1'b0, 1'b0, ROP_AND, 3'd0);
        send_item(OP_ROP_SPAN, 15'd20, 10'd9, 10'd9, 1'b1, 1'b0, ROP_CLEAR, 3'd0);
        send_item(OP_ROP_SPAN, 15'd30, 10'd0, 10'd7, 1'b0, 1'b0, ROP_SPARE_5, 3'd0);
        send_item(OP_ROP_SPAN, 15'd31, 10'd2, 10'd13, 1'b1, 1'b0, ROP_SPARE_6, 3'd0);
        send_item(OP_ROP_SPAN, 15'd40, 10'd1020, 10'd1023, 1'b0, 1'b0, ROP_SPARE_7, 3'd0);
        // Reversed spans write nothing.
        send_item(OP_ROP_SPAN, 15'd50, 10'd10, 10'd9, 1'b1, 1'b0, ROP_REPLACE, 3'd0);
        send_item(OP_PATTERN_SPAN, 15'd50, 10'd1023, 10'd0, 1'b1, 1'b0, ROP_REPLACE, 3'd0);
        // Pattern spans across all foreground and background pairs.
        send_item(OP_PATTERN_SPAN, 15'd100, 10'd5, 10'd60, 1'b1, 1'b0, ROP_REPLACE, 3'd0);
        send_item(OP_PATTERN_SPAN, 15'd110, 10'd0, 10'd63, 1'b0, 1'b1, ROP_REPLACE, 3'd7);
        send_item(OP_PATTERN_SPAN, 15'd120, 10'd3, 10'd20, 1'b1, 1'b1, ROP_REPLACE, 3'd4);
        send_item(OP_PATTERN_SPAN, 15'd130, 10'd0, 10'd1023, 1'b0, 1'b0, ROP_REPLACE, 3'd5);
        send_item(OP_NONE, 15'h7fff, 10'd1023, 10'd1023, 1'b1, 1'b1, ROP_SPARE_7, 3'd7);
        // Read back what was drawn.
        send_item(OP_READ_PIXEL, 15'h7fff, 10'd1023, 10'd0, 1'b0, 1'b0, ROP_REPLACE, 3'd0);
        send_item(OP_READ_PIXEL, 15'h7fff, 10'd4, 10'd0, 1'b0, 1'b0, ROP_REPLACE, 3'd0);
        send_item(OP_READ_PIXEL, 15'd10, 10'd12, 10'd0, 1'b0, 1'b0, ROP_REPLACE, 3'd0);
        send_item(OP_READ_PIXEL, 15'd130, 10'd7, 10'd0, 1'b0, 1'b0, ROP_REPLACE, 3'd0);
        send_item(OP_READ_PIXEL, 15'd1, 10'd9, 10'd0, 1'b0, 1'b0, ROP_REPLACE, 3'd0);

        // Random commands under four idle and stall mixes, new pattern each time.
        for (phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                    load_pattern('1);
                end
                1: begin
                    idle_pct = 79;
                    stall_pct = 0;
                    load_pattern({$urandom, $urandom});
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 79;
                    load_pattern('0);
                end
                default: begin
                    idle_pct = 37;
                    stall_pct = 37;
                    load_pattern({$urandom, $urandom} ^ 64'h55aa_33cc_0ff0_f00f);
                end
            endcase
            repeat (325) begin
                send_random_item();
                if ($urandom_range(199) == 0) wait_drained();
            end
        end

        idle_pct = 0;
        stall_pct = 0;
        wait_drained();
        $display("Ran %0d commands: %0d raster-op spans, %0d pattern spans,%s",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[0], op_count[1], "");
        $display("    %0d reads, %0d no-ops.", op_count[2], op_count[3]);
        $display("Used %0d fill patterns under four sender/receiver pressure mixes.", pattern_loads);
        if (fail_count == 0 && results_pending == 0) begin
            $display("mono_bitmap_span_rop_top regression: pass");
        end else begin
            $display("mono_bitmap_span_rop_top regression: fail");
        end
        $finish;
    end

endmodule
